@@ hdl/jll_pkg.sv @@
// Shared types and constants of the lexer: result layout, queue entry, codes.
`default_nettype none

package jll_pkg;

    // Token kinds
    localparam logic [2:0] KIND_SYMBOL = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_IDENT  = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    // Characters with special meaning
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    // Queue between the classifier and the result sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text;
        logic        byte_valid;
        logic        first;
        logic        last;
        logic [15:0] line;
        logic [15:0] col;
        logic [1:0]  err;
    } res_t;

    // An entry holds the one or two results of one accepted byte
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } entry_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   empty;
        entry_t head;
    } qhead_t;

endpackage

`default_nettype wire

@@ hdl/json_like_lexer_unit.sv @@
// Top level of the streaming lexer for a relaxed JSON format.
// Each accepted byte's results pass through the queue to the single output register.
// Throughput: one byte per cycle while the queue has room; a byte with two results
// holds the output for both, and the four-entry queue absorbs such bursts before
// input stalls. Output rate is one result per cycle while out_stall is low.
// Reset: mode idle, line and column 1, queue empty, no result valid.
`default_nettype none

module json_like_lexer_unit #(
    parameter int POS_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        doc_end,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       token_kind,
    output logic [7:0]       text_byte,
    output logic             byte_valid,
    output logic             token_first,
    output logic             token_last,
    output logic [15:0]      start_line,
    output logic [15:0]      start_col,
    output logic [1:0]       error_code,
    output logic             run_last
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    jll_pkg::entry_t entry;
    jll_pkg::qhead_t qhead;
    jll_pkg::res_t   res;

    // Hold input only when the queue has no room; a byte that yields
    // nothing still needs a free slot, which keeps the stall simple.
    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    // Front end: mode, position tracking and result formation per byte
    jll_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .doc_end (doc_end),
        .entry   (entry),
        .push    (push)
    );

    // Decouple the two sides so output stalls do not freeze lexing at once
    jll_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (entry),
        .pop      (pop),
        .qhead    (qhead),
        .full     (full)
    );

    // Back end: advance through one or two results per entry
    jll_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qhead     (qhead),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res),
        .run_last  (run_last)
    );

    assign token_kind  = res.kind;
    assign text_byte   = res.text;
    assign byte_valid  = res.byte_valid;
    assign token_first = res.first;
    assign token_last  = res.last;
    assign start_line  = res.line;
    assign start_col   = res.col;
    assign error_code  = res.err;

endmodule

`default_nettype wire

@@ hdl/jll_front.sv @@
// Lexer front end: tracks mode and position and builds the results of each byte.
`default_nettype none

module jll_front #(
    parameter int POS_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic                doc_end,
    output jll_pkg::entry_t          entry,
    output logic                     push
);

    typedef enum logic [2:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_STRING, M_ESC, M_NUMBER, M_IDENT, M_ERROR
    } mode_t;

    localparam int EXT_W = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] cur_line_reg, cur_line_next;
    logic [POS_BITS-1:0] cur_col_reg, cur_col_next;
    logic [POS_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POS_BITS-1:0] tok_col_reg, tok_col_next;

    logic [15:0] cl16, cc16, tl16, tc16;
    logic        is_digit, is_alpha, num_cont, ident_cont, is_ws, is_sym;

    jll_pkg::res_t res_a, res_b, idle_res;
    logic          use_a, use_b, idle_use, idle_tok;
    mode_t         idle_mode;

    function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > EXT_W'(16'hFFFF))
            return 16'hFFFF;
        return e[15:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == '1) ? v : v + POS_ONE;
    endfunction

    function automatic jll_pkg::res_t mk(
        input logic [2:0] kind, input logic [7:0] text, input logic bv,
        input logic first, input logic last, input logic [15:0] line,
        input logic [15:0] col, input logic [1:0] err);
        jll_pkg::res_t r;
        r.kind       = kind;
        r.text       = text;
        r.byte_valid = bv;
        r.first      = first;
        r.last       = last;
        r.line       = line;
        r.col        = col;
        r.err        = err;
        return r;
    endfunction

    assign cl16 = clamp16(cur_line_reg);
    assign cc16 = clamp16(cur_col_reg);
    assign tl16 = clamp16(tok_line_reg);
    assign tc16 = clamp16(tok_col_reg);

    assign is_digit   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign is_alpha   = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                        ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
    assign num_cont   = is_digit || in_byte == CH_DOT || in_byte == CH_MINUS ||
                        in_byte == CH_PLUS;
    assign ident_cont = is_alpha || is_digit || in_byte == jll_pkg::CH_UNDERSCORE ||
                        in_byte == CH_MINUS;
    assign is_ws      = in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR ||
                        in_byte == jll_pkg::CH_NEWLINE;
    assign is_sym     = in_byte == CH_LBRACE || in_byte == CH_RBRACE ||
                        in_byte == CH_LBRACK || in_byte == CH_RBRACK ||
                        in_byte == CH_COLON || in_byte == CH_COMMA;

    // Classify a byte seen in idle mode
    always_comb
    begin
        idle_use  = 1'b0;
        idle_res  = '0;
        idle_mode = M_IDLE;
        idle_tok  = 1'b0;
        if (is_ws)
        begin
            idle_mode = M_IDLE;
        end
        else if (in_byte == CH_SLASH)
        begin
            idle_mode = M_SLASH;
            idle_tok  = 1'b1;
        end
        else if (in_byte == jll_pkg::CH_HASH)
        begin
            idle_mode = M_COMMENT;
        end
        else if (is_sym)
        begin
            idle_use = 1'b1;
            idle_res = mk(jll_pkg::KIND_SYMBOL, in_byte, 1'b1, 1'b1, 1'b1, cl16, cc16,
                          jll_pkg::ERR_NONE);
        end
        else if (in_byte == CH_QUOTE)
        begin
            idle_use  = 1'b1;
            idle_tok  = 1'b1;
            idle_mode = M_STRING;
            idle_res  = mk(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, cl16, cc16,
                           jll_pkg::ERR_NONE);
        end
        else if (is_digit || in_byte == CH_MINUS || in_byte == CH_PLUS)
        begin
            idle_use  = 1'b1;
            idle_tok  = 1'b1;
            idle_mode = M_NUMBER;
            idle_res  = mk(jll_pkg::KIND_NUMBER, in_byte, 1'b1, 1'b1, 1'b0, cl16, cc16,
                           jll_pkg::ERR_NONE);
        end
        else if (is_alpha)
        begin
            idle_use  = 1'b1;
            idle_tok  = 1'b1;
            idle_mode = M_IDENT;
            idle_res  = mk(jll_pkg::KIND_IDENT, in_byte, 1'b1, 1'b1, 1'b0, cl16, cc16,
                           jll_pkg::ERR_NONE);
        end
        else
        begin
            idle_use  = 1'b1;
            idle_mode = M_ERROR;
            idle_res  = mk(jll_pkg::KIND_SYMBOL, in_byte, 1'b1, 1'b1, 1'b1, cl16, cc16,
                           jll_pkg::ERR_UNEXPECTED);
        end
    end

    always_comb
    begin
        logic       run_idle;
        logic [1:0] end_err;
        run_idle      = 1'b0;
        end_err       = jll_pkg::ERR_NONE;
        res_a         = '0;
        res_b         = '0;
        use_a         = 1'b0;
        use_b         = 1'b0;
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;

        if (doc_end)
        begin
            unique case (mode_reg)
                M_NUMBER:
                begin
                    use_a = 1'b1;
                    res_a = mk(jll_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, tl16, tc16,
                               jll_pkg::ERR_NONE);
                end
                M_IDENT:
                begin
                    use_a = 1'b1;
                    res_a = mk(jll_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, tl16, tc16,
                               jll_pkg::ERR_NONE);
                end
                M_STRING, M_ESC:
                begin
                    end_err = jll_pkg::ERR_UNTERM_STR;
                    use_a   = 1'b1;
                    res_a   = mk(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, tl16, tc16,
                                 jll_pkg::ERR_UNTERM_STR);
                end
                M_SLASH:
                begin
                    end_err = jll_pkg::ERR_UNEXPECTED;
                    use_a   = 1'b1;
                    res_a   = mk(jll_pkg::KIND_SYMBOL, CH_SLASH, 1'b1, 1'b1, 1'b1, tl16,
                                 tc16, jll_pkg::ERR_UNEXPECTED);
                end
                M_ERROR:
                begin
                    end_err = jll_pkg::ERR_UNEXPECTED;
                end
                default:
                begin
                    end_err = jll_pkg::ERR_NONE;
                end
            endcase
            use_b         = 1'b1;
            res_b         = mk(jll_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, cl16, cc16,
                               end_err);
            mode_next     = M_IDLE;
            cur_line_next = POS_ONE;
            cur_col_next  = POS_ONE;
            tok_line_next = POS_ONE;
            tok_col_next  = POS_ONE;
        end
        else
        begin
            unique case (mode_reg)
                M_ERROR:
                begin
                    mode_next = M_ERROR;
                end
                M_COMMENT:
                begin
                    if (in_byte == jll_pkg::CH_NEWLINE)
                        mode_next = M_IDLE;
                end
                M_SLASH:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        use_a     = 1'b1;
                        res_a     = mk(jll_pkg::KIND_SYMBOL, CH_SLASH, 1'b1, 1'b1, 1'b1,
                                       tl16, tc16, jll_pkg::ERR_UNEXPECTED);
                        mode_next = M_ERROR;
                    end
                end
                M_STRING:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        use_a     = 1'b1;
                        res_a     = mk(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1,
                                       tl16, tc16, jll_pkg::ERR_NONE);
                        mode_next = M_IDLE;
                    end
                    else if (in_byte == jll_pkg::CH_BACKSLASH)
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        use_a = 1'b1;
                        res_a = mk(jll_pkg::KIND_STRING, in_byte, 1'b1, 1'b0, 1'b0,
                                   tl16, tc16, jll_pkg::ERR_NONE);
                    end
                end
                M_ESC:
                begin
                    use_a     = 1'b1;
                    res_a     = mk(jll_pkg::KIND_STRING, in_byte, 1'b1, 1'b0, 1'b0,
                                   tl16, tc16, jll_pkg::ERR_NONE);
                    mode_next = M_STRING;
                end
                M_NUMBER:
                begin
                    use_a = 1'b1;
                    if (num_cont)
                    begin
                        res_a = mk(jll_pkg::KIND_NUMBER, in_byte, 1'b1, 1'b0, 1'b0,
                                   tl16, tc16, jll_pkg::ERR_NONE);
                    end
                    else
                    begin
                        res_a    = mk(jll_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1,
                                      tl16, tc16, jll_pkg::ERR_NONE);
                        run_idle = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    use_a = 1'b1;
                    if (ident_cont)
                    begin
                        res_a = mk(jll_pkg::KIND_IDENT, in_byte, 1'b1, 1'b0, 1'b0,
                                   tl16, tc16, jll_pkg::ERR_NONE);
                    end
                    else
                    begin
                        res_a    = mk(jll_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1,
                                      tl16, tc16, jll_pkg::ERR_NONE);
                        run_idle = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle)
            begin
                use_b     = idle_use;
                res_b     = idle_res;
                mode_next = idle_mode;
                if (idle_tok)
                begin
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                end
            end

            // Advance position unless an error is in force
            if (mode_reg != M_ERROR)
            begin
                if (in_byte == jll_pkg::CH_NEWLINE && mode_reg != M_STRING &&
                    mode_reg != M_ESC)
                begin
                    cur_line_next = sat_inc(cur_line_reg);
                    cur_col_next  = POS_ONE;
                end
                else
                begin
                    cur_col_next = sat_inc(cur_col_reg);
                end
            end
        end
    end

    assign entry.r0  = use_a ? res_a : res_b;
    assign entry.r1  = res_b;
    assign entry.two = use_a & use_b;
    assign push      = accept & (use_a | use_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            cur_line_reg <= POS_ONE;
            cur_col_reg  <= POS_ONE;
            tok_line_reg <= POS_ONE;
            tok_col_reg  <= POS_ONE;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/jll_queue.sv @@
// Short queue of result entries between the front end and the result sequencer.
`default_nettype none

module jll_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire jll_pkg::entry_t     wr_entry,
    input  wire logic                pop,
    output jll_pkg::qhead_t          qhead,
    output logic                     full
);

    jll_pkg::entry_t                  mem [jll_pkg::QUEUE_DEPTH];
    logic [jll_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [jll_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [jll_pkg::QCNT_BITS-1:0]    count_reg, count_next;

    assign full         = (count_reg == jll_pkg::QCNT_BITS'(jll_pkg::QUEUE_DEPTH));
    assign qhead.empty  = (count_reg == '0);
    assign qhead.head   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qhead.empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= jll_pkg::QCNT_BITS'(jll_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hdl/jll_back.sv @@
// Result sequencer: walks each queued entry and drives the output register.
`default_nettype none

module jll_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jll_pkg::qhead_t     qhead,
    output logic                     pop,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output jll_pkg::res_t            res,
    output logic                     run_last
);

    logic          idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    jll_pkg::res_t res_reg;
    logic          run_last_reg;
    logic          load_ok, emit, entry_done;
    jll_pkg::res_t sel;

    assign load_ok    = !out_valid_reg || !out_stall;
    assign emit       = load_ok && !qhead.empty;
    assign sel        = idx_reg ? qhead.head.r1 : qhead.head.r0;
    assign entry_done = idx_reg || !qhead.head.two;
    assign pop        = emit && entry_done;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_ok)
            out_valid_next = emit;
        if (emit)
            idx_next = !entry_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg      <= sel;
            run_last_reg <= entry_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign run_last  = run_last_reg;

    a_second_slot: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg |-> (!qhead.empty && qhead.head.two))
        else $error("second result pending without a two-result entry");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !entry_done) |=> idx_reg)
        else $error("second result of an entry skipped");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the streaming lexer: token predictor, scoreboard and drivers.

typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_ERROR
} lex_mode_t;

typedef struct packed {
    jll_pkg::res_t r;
    logic          run_last;
} lex_result_t;

class lexer_scoreboard #(int POS_BITS = 16);
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    lex_mode_t             mode;
    logic [POS_BITS-1:0]   cur_line;
    logic [POS_BITS-1:0]   cur_col;
    logic [POS_BITS-1:0]   tok_line;
    logic [POS_BITS-1:0]   tok_col;
    lex_result_t           token_q[$];
    lex_result_t           step_out[$];
    int                    errors;

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        mode     = MODE_IDLE;
        cur_line = POS_BITS'(1);
        cur_col  = POS_BITS'(1);
        tok_line = POS_BITS'(1);
        tok_col  = POS_BITS'(1);
    endfunction

    function int pending();
        return token_q.size();
    endfunction

    function logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
        return (v == {POS_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Positions leave the block 16 bits wide, clipped at the top.
    function logic [15:0] clip_pos(logic [POS_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > 33'd65535)
            return 16'hFFFF;
        return w[15:0];
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void add_result(logic [2:0] kind, logic [7:0] text, logic bv, logic first,
                             logic last, logic [POS_BITS-1:0] line,
                             logic [POS_BITS-1:0] col, logic [1:0] err);
        lex_result_t t;
        t.r.kind       = kind;
        t.r.text       = text;
        t.r.byte_valid = bv;
        t.r.first      = first;
        t.r.last       = last;
        t.r.line       = clip_pos(line);
        t.r.col        = clip_pos(col);
        t.r.err        = err;
        t.run_last     = 1'b0;
        step_out = {step_out, t};
    endfunction

    // Lex one byte from the idle mode.
    function void lex_idle(logic [7:0] b);
        case (b)
            CH_SPACE, CH_TAB, CH_CR, jll_pkg::CH_NEWLINE: ;
            "/":
            begin
                tok_line = cur_line;
                tok_col  = cur_col;
                mode     = MODE_SLASH;
            end
            jll_pkg::CH_HASH: mode = MODE_COMMENT;
            "{", "}", "[", "]", ":", ",":
                add_result(jll_pkg::KIND_SYMBOL, b, 1'b1, 1'b1, 1'b1, cur_line, cur_col,
                           jll_pkg::ERR_NONE);
            "\"":
            begin
                tok_line = cur_line;
                tok_col  = cur_col;
                mode     = MODE_STRING;
                add_result(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, tok_line, tok_col,
                           jll_pkg::ERR_NONE);
            end
            default:
            begin
                if (is_digit(b) || b == "-" || b == "+")
                begin
                    tok_line = cur_line;
                    tok_col  = cur_col;
                    mode     = MODE_NUMBER;
                    add_result(jll_pkg::KIND_NUMBER, b, 1'b1, 1'b1, 1'b0, tok_line, tok_col,
                               jll_pkg::ERR_NONE);
                end
                else if (is_alpha(b))
                begin
                    tok_line = cur_line;
                    tok_col  = cur_col;
                    mode     = MODE_IDENT;
                    add_result(jll_pkg::KIND_IDENT, b, 1'b1, 1'b1, 1'b0, tok_line, tok_col,
                               jll_pkg::ERR_NONE);
                end
                else
                begin
                    add_result(jll_pkg::KIND_SYMBOL, b, 1'b1, 1'b1, 1'b1, cur_line, cur_col,
                               jll_pkg::ERR_UNEXPECTED);
                    mode = MODE_ERROR;
                end
            end
        endcase
    endfunction

    // Note one accepted input transfer and queue the results it must cause.
    function void note_input(logic [7:0] b, logic end_mark);
        lex_mode_t  was;
        logic [1:0] err;
        step_out.delete();
        was = mode;
        if (end_mark)
        begin
            err = jll_pkg::ERR_NONE;
            case (was)
                MODE_NUMBER:
                    add_result(jll_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, tok_line, tok_col,
                               jll_pkg::ERR_NONE);
                MODE_IDENT:
                    add_result(jll_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, tok_line, tok_col,
                               jll_pkg::ERR_NONE);
                MODE_STRING, MODE_ESCAPE:
                begin
                    err = jll_pkg::ERR_UNTERM_STR;
                    add_result(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, tok_line, tok_col,
                               err);
                end
                MODE_SLASH:
                begin
                    err = jll_pkg::ERR_UNEXPECTED;
                    add_result(jll_pkg::KIND_SYMBOL, "/", 1'b1, 1'b1, 1'b1, tok_line, tok_col,
                               err);
                end
                MODE_ERROR: err = jll_pkg::ERR_UNEXPECTED;
                default: ;
            endcase
            add_result(jll_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, cur_line, cur_col, err);
            reset_state();
        end
        else if (was != MODE_ERROR)
        begin
            case (was)
                MODE_COMMENT:
                    if (b == jll_pkg::CH_NEWLINE)
                        mode = MODE_IDLE;
                MODE_SLASH:
                begin
                    if (b == "/")
                        mode = MODE_COMMENT;
                    else
                    begin
                        add_result(jll_pkg::KIND_SYMBOL, "/", 1'b1, 1'b1, 1'b1, tok_line,
                                   tok_col, jll_pkg::ERR_UNEXPECTED);
                        mode = MODE_ERROR;
                    end
                end
                MODE_STRING:
                begin
                    if (b == "\"")
                    begin
                        add_result(jll_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    else if (b == jll_pkg::CH_BACKSLASH)
                        mode = MODE_ESCAPE;
                    else
                        add_result(jll_pkg::KIND_STRING, b, 1'b1, 1'b0, 1'b0, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                end
                MODE_ESCAPE:
                begin
                    add_result(jll_pkg::KIND_STRING, b, 1'b1, 1'b0, 1'b0, tok_line, tok_col,
                               jll_pkg::ERR_NONE);
                    mode = MODE_STRING;
                end
                MODE_NUMBER:
                begin
                    if (is_digit(b) || b == "." || b == "-" || b == "+")
                        add_result(jll_pkg::KIND_NUMBER, b, 1'b1, 1'b0, 1'b0, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                    else
                    begin
                        add_result(jll_pkg::KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                        mode = MODE_IDLE;
                        lex_idle(b);
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == jll_pkg::CH_UNDERSCORE || b == "-")
                        add_result(jll_pkg::KIND_IDENT, b, 1'b1, 1'b0, 1'b0, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                    else
                    begin
                        add_result(jll_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, tok_line,
                                   tok_col, jll_pkg::ERR_NONE);
                        mode = MODE_IDLE;
                        lex_idle(b);
                    end
                end
                default:
                begin
                    mode = MODE_IDLE;
                    lex_idle(b);
                end
            endcase
            // Inside a string a newline only moves the column.
            if (b == jll_pkg::CH_NEWLINE && was != MODE_STRING && was != MODE_ESCAPE)
            begin
                cur_line = sat_inc(cur_line);
                cur_col  = POS_BITS'(1);
            end
            else
                cur_col = sat_inc(cur_col);
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].run_last = 1'b1;
        token_q = {token_q, step_out};
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Check one accepted result transfer against the oldest expected token result.
    function void check_result(lex_result_t got);
        lex_result_t want;
        if (token_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing expected: expected none, actual kind %0d text %0h",
                     $time, got.r.kind, got.r.text);
            return;
        end
        want = token_q.pop_front();
        compare_field("token_kind", 16'(want.r.kind), 16'(got.r.kind));
        compare_field("text_byte", 16'(want.r.text), 16'(got.r.text));
        compare_field("byte_valid", 16'(want.r.byte_valid), 16'(got.r.byte_valid));
        compare_field("token_first", 16'(want.r.first), 16'(got.r.first));
        compare_field("token_last", 16'(want.r.last), 16'(got.r.last));
        compare_field("start_line", want.r.line, got.r.line);
        compare_field("start_col", want.r.col, got.r.col);
        compare_field("error_code", 16'(want.r.err), 16'(got.r.err));
        compare_field("run_last", 16'(want.run_last), 16'(got.run_last));
    endfunction
endclass

module testbench;

    localparam int POS_BITS    = 16;
    // Longest quiet stretch tolerated: far beyond any random gap or stall run.
    localparam int QUIET_LIMIT = 2000;
    localparam int ROUND_ITEMS = 225;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        doc_end;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  token_kind;
    logic [7:0]  text_byte;
    logic        byte_valid;
    logic        token_first;
    logic        token_last;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [1:0]  error_code;
    logic        run_last;

    lexer_scoreboard #(POS_BITS) sb;

    // Source text of the document being built, sent byte by byte.
    logic [7:0]  text_q[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    int          quiet_cycles   = 0;

    json_like_lexer_unit #(
        .POS_BITS(POS_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .doc_end(doc_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .token_kind(token_kind),
        .text_byte(text_byte),
        .byte_valid(byte_valid),
        .token_first(token_first),
        .token_last(token_last),
        .start_line(start_line),
        .start_col(start_col),
        .error_code(error_code),
        .run_last(run_last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: stall at random at the falling edge, at the rate of the current phase.
    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);

    // Sample both channels at the rising edge; note inputs before checking results.
    // The watchdog counts edges with no transfer on either side.
    always @(posedge clk)
    begin : sample_channels
        lex_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_byte, doc_end);
            if (out_valid && !out_stall)
            begin
                got.r.kind       = token_kind;
                got.r.text       = text_byte;
                got.r.byte_valid = byte_valid;
                got.r.first      = token_first;
                got.r.last       = token_last;
                got.r.line       = start_line;
                got.r.col        = start_col;
                got.r.err        = error_code;
                got.run_last     = run_last;
                sb.check_result(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Present one item: idle at random first, then hold it until the transfer.
    task automatic send_item(input logic [7:0] b, input logic end_mark);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        doc_end  = end_mark;
        items_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send the built text, then the end marker with a random ignored byte.
    task automatic send_document();
        foreach (text_q[i])
            send_item(text_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        text_q.delete();
    endtask

    // Drop valid and hold off until every expected result has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Append one byte to the document text.
    function automatic void add_byte(logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // Append one random token; mostly well-formed, with rare noise bytes.
    function automatic void add_token();
        int          sel;
        int          n;
        logic [7:0]  c;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            add_byte(pick("{}[]:,"));
        else if (sel < 28)
        begin
            case ($urandom_range(0, 3))
                0: add_byte(8'h20);
                1: add_byte(8'h09);
                2: add_byte(8'h0D);
                default: add_byte(jll_pkg::CH_NEWLINE);
            endcase
        end
        else if (sel < 48)
        begin
            add_byte("\"");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    add_byte(jll_pkg::CH_BACKSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                else
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == "\"" || c == jll_pkg::CH_BACKSLASH)
                        c = "z";
                    add_byte(c);
                end
            end
            add_byte("\"");
        end
        else if (sel < 64)
        begin
            add_byte(pick("0123456789-+"));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                add_byte(pick("0123456789.-+"));
        end
        else if (sel < 80)
        begin
            add_byte(rand_letter());
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    add_byte(pick("0123456789_-"));
                else
                    add_byte(rand_letter());
            end
        end
        else if (sel < 90)
        begin
            if ($urandom_range(0, 1) == 0)
                add_byte(jll_pkg::CH_HASH);
            else
                add_str("//");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == jll_pkg::CH_NEWLINE)
                    c = "c";
                add_byte(c);
            end
            add_byte(jll_pkg::CH_NEWLINE);
        end
        else if (sel < 97)
            add_byte(jll_pkg::CH_NEWLINE);
        else
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    // Build one random document; some end in an open string or a lone slash.
    function automatic void build_document();
        int sel;
        int ntok;
        ntok = $urandom_range(1, 12);
        for (int i = 0; i < ntok; i++)
            add_token();
        sel = $urandom_range(0, 99);
        if (sel < 5)
            add_str("\"open");
        else if (sel < 8)
            add_str("\"\\");
        else if (sel < 11)
            add_str("/");
    endfunction

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = 8'h00;
        doc_end   = 1'b0;
        out_stall = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed documents, no idling.
        // Symbols, identifier with underscore and dash, number closed by a quote,
        // escaped quote and a newline inside a string.
        add_str("{a_-9:-1.\"\\\"\n\"]");
        send_document();
        // Blanks, both comment styles, number closed by the end marker.
        add_str("\t#\n//");
        add_byte(8'h0D);
        add_str("\n+");
        send_document();
        // Unterminated string, plain and right after its backslash.
        add_str("\"ab");
        send_document();
        add_str("\"\\");
        send_document();
        // Lone slash, then an error in force that swallows the rest.
        add_str("/,");
        add_byte(8'h00);
        send_document();
        // Slash right before the end marker.
        add_str("/");
        send_document();
        // High byte is unexpected; identifier closed by the end marker first.
        add_str("q");
        send_document();
        add_byte(8'hFF);
        add_str("x");
        send_document();
        // Backslash outside a string.
        add_byte(jll_pkg::CH_BACKSLASH);
        send_document();
        drain_results();

        // Random documents through the idling phases, draining between phases.
        for (int round = 0; round < 8; round++)
        begin
            case (round % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            items_sent = 0;
            while (items_sent < ROUND_ITEMS)
            begin
                build_document();
                send_document();
            end
            drain_results();
        end

        // Let any stray result show up before the verdict.
        recv_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ json_like_lexer_unit.f @@
hdl/jll_pkg.sv
hdl/jll_front.sv
hdl/jll_queue.sv
hdl/jll_back.sv
hdl/json_like_lexer_unit.sv
tb/testbench.sv
